// ===== src/assert_macros.svh =====
// assertion macros used by the checker file bbc_checker.sv
// no dependencies; take in with `include
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at every rising edge outside reset
`define BBC_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("bbc assertion failed");

// same check with reset ignored
`define BBC_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("bbc assertion failed");

`endif

// ===== src/bbc_pkg.sv =====
// types, constants and decode functions of the bracket balance checker
// no dependencies
`default_nettype none

package bbc_pkg;

   localparam int MAX_DEPTH = 64;
   localparam int DEPTH_W   = $clog2(MAX_DEPTH + 1);
   localparam int CHAR_W    = 8;
   localparam int VERDICT_W = 3;
   localparam int NEST_W    = 7;

   typedef enum logic [1:0] {
      KIND_ROUND  = 2'd0,
      KIND_SQUARE = 2'd1,
      KIND_CURLY  = 2'd2,
      KIND_NONE   = 2'd3
   } kind_type;

   typedef enum logic [VERDICT_W-1:0] {
      VERDICT_OK       = 3'd0,
      VERDICT_MISMATCH = 3'd1,
      VERDICT_EMPTY    = 3'd2,
      VERDICT_UNCLOSED = 3'd3,
      VERDICT_OVERFLOW = 3'd4
   } verdict_type;

   // one step of the stack row
   typedef struct packed {
      logic     push;
      logic     pop;
      kind_type kind;
   } stack_op_type;

   // one result word
   typedef struct packed {
      logic                 done_res;
      logic [VERDICT_W-1:0] verdict;
      logic [NEST_W-1:0]    nesting_depth;
   } rsp_word_type;

   function automatic kind_type opener_kind(input logic [CHAR_W-1:0] c);
      kind_type k;
      unique case (c)
         8'h28:   k = KIND_ROUND;
         8'h5B:   k = KIND_SQUARE;
         8'h7B:   k = KIND_CURLY;
         default: k = KIND_NONE;
      endcase
      return k;
   endfunction

   function automatic kind_type closer_kind(input logic [CHAR_W-1:0] c);
      kind_type k;
      unique case (c)
         8'h29:   k = KIND_ROUND;
         8'h5D:   k = KIND_SQUARE;
         8'h7D:   k = KIND_CURLY;
         default: k = KIND_NONE;
      endcase
      return k;
   endfunction

endpackage

`default_nettype wire

// ===== src/bbc_intf.sv =====
// request and response channel interfaces of the bracket balance checker
// depends on bbc_pkg
`default_nettype none

interface bbc_req_if;
   logic                          valid;
   logic                          ready;
   logic [bbc_pkg::CHAR_W-1:0]    character;
   logic                          last_char;

   modport source (output valid, output character, output last_char, input ready);
   modport sink   (input valid, input character, input last_char, output ready);
endinterface

interface bbc_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          done_res;
   logic [bbc_pkg::VERDICT_W-1:0] verdict;
   logic [bbc_pkg::NEST_W-1:0]    nesting_depth;

   modport source (output valid, output done_res, output verdict, output nesting_depth,
                   input ready);
   modport sink   (input valid, input done_res, input verdict, input nesting_depth,
                   output ready);
endinterface

`default_nettype wire

// ===== src/bbc_cell.sv =====
// one stack cell: holds one bracket kind, shifts with its neighbors
// depends on bbc_pkg
`default_nettype none

module bbc_cell (
   input  wire                    clock,
   input  bbc_pkg::stack_op_type  op,
   input  bbc_pkg::kind_type      from_above,
   input  bbc_pkg::kind_type      from_below,
   output bbc_pkg::kind_type      kind
);
   import bbc_pkg::*;

   kind_type kind_ff;
   kind_type kind_in;

   // push takes the shallower neighbor, pop the deeper one
   always_comb begin
      priority if (op.push) begin
         kind_in = from_above;
      end else if (op.pop) begin
         kind_in = from_below;
      end else begin
         kind_in = kind_ff;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
   end

   assign kind = kind_ff;

endmodule

`default_nettype wire

// ===== src/bbc_stack.sv =====
// bracket stack as a row of shifting cells, top of stack in cell 0
// depends on bbc_pkg, bbc_cell
`default_nettype none

module bbc_stack (
   input  wire                    clock,
   input  bbc_pkg::stack_op_type  op,
   output bbc_pkg::kind_type      top_kind
);
   import bbc_pkg::*;

   kind_type cell_kind [MAX_DEPTH];

   // row of cells, each fed by its two neighbors
   for (genvar i = 0; i < MAX_DEPTH; i++) begin : g_cell
      kind_type above;
      kind_type below;

      if (i == 0) begin : g_top
         assign above = op.kind;
      end else begin : g_mid
         assign above = cell_kind[i-1];
      end

      if (i == MAX_DEPTH - 1) begin : g_bottom
         assign below = KIND_NONE;
      end else begin : g_inner
         assign below = cell_kind[i+1];
      end

      bbc_cell u_cell (
         .clock      (clock),
         .op         (op),
         .from_above (above),
         .from_below (below),
         .kind       (cell_kind[i])
      );
   end

   assign top_kind = cell_kind[0];

endmodule

`default_nettype wire

// ===== src/bbc_skid.sv =====
// output register with one skid entry on the response side
// depends on bbc_pkg
`default_nettype none

module bbc_skid (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    in_valid,
   input  bbc_pkg::rsp_word_type  in_word,
   output logic                   in_ready,
   output logic                   out_valid,
   output bbc_pkg::rsp_word_type  out_word,
   input  wire                    out_ready
);
   import bbc_pkg::*;

   logic         main_valid_ff, main_valid_in;
   logic         skid_valid_ff, skid_valid_in;
   rsp_word_type main_ff, main_in;
   rsp_word_type skid_ff, skid_in;
   logic         take;

   assign take = main_valid_ff & out_ready;

   // refill main from skid first, then from the new word
   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      priority if (skid_valid_ff) begin
         if (take) begin
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (in_valid) begin
         if (!main_valid_ff || take) begin
            main_in       = in_word;
            main_valid_in = 1'b1;
         end else begin
            skid_in       = in_word;
            skid_valid_in = 1'b1;
         end
      end else if (take) begin
         main_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign in_ready  = ~skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_word  = main_ff;

endmodule

`default_nettype wire

// ===== src/bracket_balance_checker_unit.sv =====
// Bracket balance checker for round, square and curly brackets.
// Request channel req_ch: one byte (character) per word, last_char marks the
// final byte of a string. Response channel rsp_ch: exactly one word per
// request word, in order: done_res (copy of last_char), verdict (0 ok,
// 1 mismatched closer, 2 closer on empty stack, 3 unclosed at end,
// 4 overflow) and nesting_depth (open brackets after this byte).
// Intermediate words carry the first error seen so far; on the last byte the
// verdict is final and the depth count and error clear for the next string.
// The response word is registered in the output register (bbc_skid).
// Throughput: one byte per cycle while req_ch.ready is high; the stack is a
// row of 64 cells that all shift up or down in the same cycle.
// Reset (synchronous) empties the stack count, clears the error and drops
// both output entries. When the receiver stalls, one more word lands in a
// skid entry and req_ch.ready falls until the receiver drains it.
// depends on bbc_pkg, bbc_intf, bbc_stack, bbc_cell, bbc_skid
`default_nettype none

module bracket_balance_checker_unit (
   input  wire          clock,
   input  wire          reset,
   bbc_req_if.sink      req_ch,
   bbc_rsp_if.source    rsp_ch
);
   import bbc_pkg::*;

   logic [DEPTH_W-1:0] depth_ff, depth_in, depth_next;
   verdict_type        err_ff, err_in, err_next;
   kind_type           open_k, close_k, top_kind;
   stack_op_type       op;
   rsp_word_type       word;
   logic               accept, in_ready, no_err, do_open, do_close;
   logic               overflow, empty_close;
   verdict_type        verdict;

   assign accept = req_ch.valid & in_ready;
   assign req_ch.ready = in_ready;

   // decode the byte
   assign open_k   = opener_kind(req_ch.character);
   assign close_k  = closer_kind(req_ch.character);
   assign no_err   = (err_ff == VERDICT_OK);
   assign do_open  = no_err & (open_k != KIND_NONE);
   assign do_close = no_err & (close_k != KIND_NONE);

   assign overflow    = do_open & (depth_ff == DEPTH_W'(MAX_DEPTH));
   assign empty_close = do_close & (depth_ff == '0);

   // stack step
   assign op.push = accept & do_open & ~overflow;
   assign op.pop  = accept & do_close & ~empty_close;
   assign op.kind = open_k;

   bbc_stack u_stack (
      .clock    (clock),
      .op       (op),
      .top_kind (top_kind)
   );

   // next depth and sticky error
   always_comb begin
      priority if (op.push) begin
         depth_next = depth_ff + DEPTH_W'(1);
      end else if (op.pop) begin
         depth_next = depth_ff - DEPTH_W'(1);
      end else begin
         depth_next = depth_ff;
      end

      priority if (overflow) begin
         err_next = VERDICT_OVERFLOW;
      end else if (empty_close) begin
         err_next = VERDICT_EMPTY;
      end else if (do_close && top_kind != close_k) begin
         err_next = VERDICT_MISMATCH;
      end else begin
         err_next = err_ff;
      end

      if (req_ch.last_char && err_next == VERDICT_OK && depth_next != '0) begin
         verdict = VERDICT_UNCLOSED;
      end else begin
         verdict = err_next;
      end

      depth_in = depth_ff;
      err_in   = err_ff;
      if (accept) begin
         if (req_ch.last_char) begin
            depth_in = '0;
            err_in   = VERDICT_OK;
         end else begin
            depth_in = depth_next;
            err_in   = err_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff <= '0;
         err_ff   <= VERDICT_OK;
      end else begin
         depth_ff <= depth_in;
         err_ff   <= err_in;
      end
   end

   // result word into the output register
   assign word.done_res      = req_ch.last_char;
   assign word.verdict       = verdict;
   assign word.nesting_depth = NEST_W'(depth_next);

   rsp_word_type out_word;

   bbc_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_word   (word),
      .in_ready  (in_ready),
      .out_valid (rsp_ch.valid),
      .out_word  (out_word),
      .out_ready (rsp_ch.ready)
   );

   assign rsp_ch.done_res      = out_word.done_res;
   assign rsp_ch.verdict       = out_word.verdict;
   assign rsp_ch.nesting_depth = out_word.nesting_depth;

endmodule

`default_nettype wire

// ===== src/bbc_checker.sv =====
// port-level checks of the bracket balance checker, bound to the top level
// depends on bbc_pkg, assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module bbc_checker (
   input wire                          clock,
   input wire                          reset,
   input wire                          rsp_valid,
   input wire                          rsp_ready,
   input wire                          rsp_done_res,
   input wire [bbc_pkg::VERDICT_W-1:0] rsp_verdict,
   input wire [bbc_pkg::NEST_W-1:0]    rsp_nesting_depth
);
   import bbc_pkg::*;

   // a stalled word holds
   `BBC_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_verdict) && $stable(rsp_nesting_depth) && $stable(rsp_done_res))

   // depth never exceeds the stack size
   `BBC_ASSERT(a_depth_range, clock, reset, rsp_valid |-> rsp_nesting_depth <= NEST_W'(MAX_DEPTH))

   // unclosed is only reported on the final word
   `BBC_ASSERT(a_unclosed_final, clock, reset, rsp_valid && rsp_verdict == VERDICT_UNCLOSED |-> rsp_done_res)

   // a balanced final verdict leaves nothing open
   `BBC_ASSERT(a_balanced_empty, clock, reset, rsp_valid && rsp_done_res && rsp_verdict == VERDICT_OK |-> rsp_nesting_depth == '0)

   // no response word right after reset
   `BBC_ASSERT_ALWAYS(a_reset_idle, clock, $past(reset) |-> !rsp_valid)

endmodule

bind bracket_balance_checker_unit bbc_checker u_bbc_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_ch.valid),
   .rsp_ready         (rsp_ch.ready),
   .rsp_done_res      (rsp_ch.done_res),
   .rsp_verdict       (rsp_ch.verdict),
   .rsp_nesting_depth (rsp_ch.nesting_depth)
);

`default_nettype wire

// ===== test/bbc_verdict_checker.sv =====
`timescale 1ns / 1ps
// verdict checker for the bracket balance checker: watches both channels, keeps its
// own bracket stack and compares every response word with the predicted one
// depends on bbc_pkg and bbc_intf
`default_nettype none

module bbc_verdict_checker (
   input  wire  clock,
   input  wire  reset,
   bbc_req_if   req_ch,
   bbc_rsp_if   rsp_ch,
   output int   fail_count,
   output int   backlog
);
   import bbc_pkg::*;

   // bracket characters
   localparam logic [CHAR_W-1:0] CH_ROUND_OPEN   = "(";
   localparam logic [CHAR_W-1:0] CH_SQUARE_OPEN  = "[";
   localparam logic [CHAR_W-1:0] CH_CURLY_OPEN   = "{";
   localparam logic [CHAR_W-1:0] CH_ROUND_CLOSE  = ")";
   localparam logic [CHAR_W-1:0] CH_SQUARE_CLOSE = "]";
   localparam logic [CHAR_W-1:0] CH_CURLY_CLOSE  = "}";

   // predicted state of the string in flight
   kind_type     kind_stack [MAX_DEPTH];
   int           open_count;
   verdict_type  sticky_error;
   rsp_word_type expected_words [$];

   // one character through the predicted stack, returns the word it causes
   function automatic rsp_word_type advance_balance(input logic [CHAR_W-1:0] c,
                                                    input logic last);
      kind_type     opened;
      kind_type     closed;
      rsp_word_type w;
      opened = KIND_NONE;
      closed = KIND_NONE;
      case (c)
         CH_ROUND_OPEN:   opened = KIND_ROUND;
         CH_SQUARE_OPEN:  opened = KIND_SQUARE;
         CH_CURLY_OPEN:   opened = KIND_CURLY;
         CH_ROUND_CLOSE:  closed = KIND_ROUND;
         CH_SQUARE_CLOSE: closed = KIND_SQUARE;
         CH_CURLY_CLOSE:  closed = KIND_CURLY;
         default: ;
      endcase
      // after the first error the stack is frozen until the string ends
      if (sticky_error == VERDICT_OK) begin
         if (opened != KIND_NONE) begin
            if (open_count >= MAX_DEPTH) begin
               sticky_error = VERDICT_OVERFLOW;
            end else begin
               kind_stack[open_count] = opened;
               open_count++;
            end
         end else if (closed != KIND_NONE) begin
            if (open_count == 0) begin
               sticky_error = VERDICT_EMPTY;
            end else begin
               // pop first, then compare the popped kind
               open_count--;
               if (kind_stack[open_count] != closed) sticky_error = VERDICT_MISMATCH;
            end
         end
      end
      w.done_res      = last;
      w.verdict       = sticky_error;
      if (last && sticky_error == VERDICT_OK && open_count != 0) w.verdict = VERDICT_UNCLOSED;
      w.nesting_depth = open_count[NEST_W-1:0];
      // string done: count and error clear, stack contents stay
      if (last) begin
         open_count   = 0;
         sticky_error = VERDICT_OK;
      end
      return w;
   endfunction

   initial begin
      fail_count = 0;
      backlog    = 0;
   end

   // compare accepted responses, then predict accepted requests
   always @(posedge clock) begin
      rsp_word_type want;
      if (reset) begin
         open_count   = 0;
         sticky_error = VERDICT_OK;
         expected_words.delete();
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_words.size() == 0) begin
               $error("response word with no request waiting");
               fail_count++;
            end else begin
               want = expected_words.pop_front();
               if (rsp_ch.done_res !== want.done_res) begin
                  $error("done_res expected %0d actual %0d", want.done_res, rsp_ch.done_res);
                  fail_count++;
               end
               if (rsp_ch.verdict !== want.verdict) begin
                  $error("verdict expected %0d actual %0d", want.verdict, rsp_ch.verdict);
                  fail_count++;
               end
               if (rsp_ch.nesting_depth !== want.nesting_depth) begin
                  $error("nesting_depth expected %0d actual %0d",
                         want.nesting_depth, rsp_ch.nesting_depth);
                  fail_count++;
               end
            end
         end
         if (req_ch.valid && req_ch.ready)
            expected_words = {expected_words,
                              advance_balance(req_ch.character, req_ch.last_char)};
      end
      backlog = expected_words.size();
   end

endmodule

`default_nettype wire

// ===== test/tb_bracket_balance_checker_unit.sv =====
`timescale 1ns / 1ps
// top of the bracket balance checker testbench: clock, reset, character strings
// and response stalls; the verdict checker does the prediction and comparison
// depends on bbc_pkg, bbc_intf, bbc_verdict_checker and bracket_balance_checker_unit
`default_nettype none

module tb_bracket_balance_checker_unit;
   import bbc_pkg::*;

   localparam int CYCLE_LIMIT  = 500000;
   localparam int RANDOM_WORDS = 1200;
   localparam int CALM_TAIL    = 150;

   typedef enum int {
      SHAPE_BALANCED,
      SHAPE_MISMATCH,
      SHAPE_STRAY,
      SHAPE_UNCLOSED,
      SHAPE_NOISE,
      SHAPE_FULL,
      SHAPE_OVERFLOW
   } shape_type;

   logic clock;
   logic reset;
   int   fail_count;
   int   backlog;
   int   cycle_count;
   int   words_sent;
   bit   idle_on;
   bit   gap_phase;
   logic [CHAR_W-1:0] line_bytes [$];

   bbc_req_if req_ch ();
   bbc_rsp_if rsp_ch ();

   bracket_balance_checker_unit i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   bbc_verdict_checker i_checker (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .rsp_ch     (rsp_ch),
      .fail_count (fail_count),
      .backlog    (backlog)
   );

   // 4 ns clock
   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   // run limit
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_bracket_balance_checker_unit failed");
         $finish;
      end
   end

   // response stalls: bursts of random length, in phases with and without them
   int stall_left;
   int phase_left;
   bit stall_phase;
   initial begin
      stall_left  = 0;
      phase_left  = 0;
      stall_phase = 1'b0;
   end
   always @(negedge clock) begin
      if (phase_left == 0) begin
         stall_phase = $urandom_range(0, 2) != 0;
         phase_left  = $urandom_range(50, 300);
      end else begin
         phase_left--;
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_ch.ready <= 1'b0;
      end else if (idle_on && stall_phase && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(0, 9);
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   function automatic logic [CHAR_W-1:0] bracket_char(input int kind, input bit closing);
      case (kind)
         KIND_ROUND:  return closing ? ")" : "(";
         KIND_SQUARE: return closing ? "]" : "[";
         default:     return closing ? "}" : "{";
      endcase
   endfunction

   // one word on the request channel, with an optional gap before it
   task automatic send_word(input logic [CHAR_W-1:0] c, input logic last);
      int gap;
      if (idle_on && gap_phase && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 10);
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.character <= c;
      req_ch.last_char <= last;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      @(negedge clock);
      words_sent++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_word(s[i], i == s.len() - 1);
   endtask

   task automatic send_line();
      for (int i = 0; i < line_bytes.size(); i++)
         send_word(line_bytes[i], i == line_bytes.size() - 1);
   endtask

   // builds one string of the given shape into line_bytes
   task automatic compose_line(input shape_type shape);
      int open_q [$];
      int cap;
      int len;
      int r;
      int k;
      line_bytes.delete();
      case (shape)
         SHAPE_NOISE: begin
            len = $urandom_range(1, 8);
            repeat (len) line_bytes = {line_bytes, CHAR_W'($urandom_range(0, 255))};
         end
         SHAPE_FULL, SHAPE_OVERFLOW: begin
            // fill the stack to the limit, one more opener overflows it
            repeat (MAX_DEPTH + (shape == SHAPE_OVERFLOW ? 1 : 0)) begin
               k = $urandom_range(0, 2);
               open_q     = {open_q, k};
               line_bytes = {line_bytes, bracket_char(k, 1'b0)};
            end
            if (shape == SHAPE_OVERFLOW) begin
               repeat ($urandom_range(0, 4))
                  line_bytes = {line_bytes, CHAR_W'($urandom_range(0, 255))};
               open_q.delete();
            end
         end
         default: begin
            cap = $urandom_range(1, 8);
            len = $urandom_range(0, 16);
            repeat (len) begin
               r = $urandom_range(0, 9);
               if (r < 4 && open_q.size() < cap) begin
                  k = $urandom_range(0, 2);
                  open_q     = {open_q, k};
                  line_bytes = {line_bytes, bracket_char(k, 1'b0)};
               end else if (r < 7 && open_q.size() > 0) begin
                  k = open_q.pop_back();
                  line_bytes = {line_bytes, bracket_char(k, 1'b1)};
               end else begin
                  line_bytes = {line_bytes, CHAR_W'($urandom_range(0, 255))};
               end
            end
            // plant the error, then a few characters that must be ignored
            if (shape == SHAPE_MISMATCH) begin
               if (open_q.size() == 0) begin
                  k = $urandom_range(0, 2);
                  open_q     = {open_q, k};
                  line_bytes = {line_bytes, bracket_char(k, 1'b0)};
               end
               k = open_q.pop_back();
               line_bytes = {line_bytes, bracket_char((k + $urandom_range(1, 2)) % 3, 1'b1)};
               repeat ($urandom_range(0, 3))
                  line_bytes = {line_bytes, CHAR_W'($urandom_range(0, 255))};
            end else if (shape == SHAPE_STRAY) begin
               while (open_q.size() > 0)
                  line_bytes = {line_bytes, bracket_char(open_q.pop_back(), 1'b1)};
               line_bytes = {line_bytes, bracket_char($urandom_range(0, 2), 1'b1)};
               repeat ($urandom_range(0, 3))
                  line_bytes = {line_bytes, CHAR_W'($urandom_range(0, 255))};
            end else if (shape == SHAPE_UNCLOSED) begin
               if (open_q.size() == 0)
                  line_bytes = {line_bytes, bracket_char($urandom_range(0, 2), 1'b0)};
               open_q.delete();
            end
         end
      endcase
      while (open_q.size() > 0)
         line_bytes = {line_bytes, bracket_char(open_q.pop_back(), 1'b1)};
      if (line_bytes.size() == 0) line_bytes = {line_bytes, CHAR_W'($urandom_range(0, 255))};
   endtask

   // stimulus and verdict
   initial begin
      shape_type shape;
      int        line_no;
      int        pick;
      reset            = 1'b1;
      req_ch.valid     = 1'b0;
      req_ch.character = '0;
      req_ch.last_char = 1'b0;
      rsp_ch.ready     = 1'b0;
      idle_on          = 1'b1;
      gap_phase        = 1'b1;
      words_sent       = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed strings: balanced, closer on empty, mismatch, unclosed, sticky error
      send_text("()");
      send_text("([{}])");
      send_text("x");
      send_text(")");
      send_text("(]");
      send_text("{");
      send_text("[)]]");
      send_text("})");
      send_word(8'h00, 1'b0);
      send_word(8'hFF, 1'b1);

      // random strings, mostly well formed; first a full stack and an overflow
      line_no = 0;
      while (words_sent < RANDOM_WORDS) begin
         if (words_sent >= RANDOM_WORDS - CALM_TAIL) idle_on = 1'b0;
         gap_phase = $urandom_range(0, 3) != 0;
         pick = $urandom_range(0, 99);
         if (line_no == 0)     shape = SHAPE_FULL;
         else if (line_no == 1) shape = SHAPE_OVERFLOW;
         else if (pick < 45)   shape = SHAPE_BALANCED;
         else if (pick < 60)   shape = SHAPE_MISMATCH;
         else if (pick < 70)   shape = SHAPE_STRAY;
         else if (pick < 82)   shape = SHAPE_UNCLOSED;
         else if (pick < 94)   shape = SHAPE_NOISE;
         else if (pick < 97)   shape = SHAPE_FULL;
         else                  shape = SHAPE_OVERFLOW;
         compose_line(shape);
         send_line();
         line_no++;
      end
      req_ch.valid <= 1'b0;

      // drain, then wait for any stray word
      while (backlog != 0) @(negedge clock);
      repeat (8) @(negedge clock);
      if (fail_count == 0) begin
         $display("tb_bracket_balance_checker_unit passed");
      end else begin
         $display("tb_bracket_balance_checker_unit failed");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== files.f =====
+incdir+src
src/bbc_pkg.sv
src/bbc_intf.sv
src/bbc_cell.sv
src/bbc_stack.sv
src/bbc_skid.sv
src/bracket_balance_checker_unit.sv
src/bbc_checker.sv
test/bbc_verdict_checker.sv
test/tb_bracket_balance_checker_unit.sv
